@@ hdl/nfe_pkg.sv @@
package nfe_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // register select, taken from paddr[2]
    localparam logic REG_FIELD_INDEX = 1'b0;
    localparam logic REG_HEX_MODE    = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    localparam logic [7:0]  SIGN_CHAR = 8'h2D;
    localparam logic [3:0]  RUN_CAP   = 4'd15;
    localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [3:0] field_index;
        logic       hex_mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value;
    } result_t;

    // {is_digit, digit value}
    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
        logic [4:0] d;
        d = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = {1'b1, 4'(c - 8'h30)};
        end
        else if (hex && c >= 8'h61 && c <= 8'h66)
        begin
            d = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        else if (hex && c >= 8'h41 && c <= 8'h46)
        begin
            d = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return d;
    endfunction

endpackage

@@ hdl/nfe_cfg.sv @@
module nfe_cfg
    import nfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [3:0] field_index_reg;
    logic       hex_mode_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg <= 4'd0;
            hex_mode_reg    <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_FIELD_INDEX: field_index_reg <= pwdata[3:0];
                REG_HEX_MODE:    hex_mode_reg    <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FIELD_INDEX: prdata = {{(DATA_W-4){1'b0}}, field_index_reg};
            REG_HEX_MODE:    prdata = {{(DATA_W-1){1'b0}}, hex_mode_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.field_index = field_index_reg;
    assign cfg.hex_mode    = hex_mode_reg;

endmodule

@@ hdl/nfe_scan.sv @@
module nfe_scan
    import nfe_pkg::*;
#(
    parameter int MAX_TEXT_LEN = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       step,
    input  logic [7:0] text_byte,
    input  logic       last_byte,
    output result_t    result
);

    localparam int CW = $clog2(MAX_TEXT_LEN + 2);
    localparam logic [CW-1:0] LEN_LIMIT = CW'(MAX_TEXT_LEN);

    localparam logic [1:0] PH_SIGN   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    logic [CW-1:0] char_count_reg,  char_count_next;
    logic          text_ended_reg,  text_ended_next;
    logic          inside_run_reg,  inside_run_next;
    logic [3:0]    runs_seen_reg,   runs_seen_next;
    logic          selected_reg,    selected_next;
    logic [1:0]    phase_reg,       phase_next;
    logic          negative_reg,    negative_next;
    logic [63:0]   magnitude_reg,   magnitude_next;

    logic [4:0]  digit;
    logic        is_digit;
    logic        run_char;
    logic        start_sel;
    logic [63:0] mag_base;
    logic [67:0] product;
    logic [67:0] sum;
    logic [63:0] acc;

    assign digit     = digit_of(text_byte, cfg.hex_mode);
    assign is_digit  = digit[4];
    assign run_char  = is_digit || (text_byte == SIGN_CHAR);
    assign start_sel = run_char && !inside_run_reg && (runs_seen_reg < RUN_CAP)
                       && (runs_seen_reg == cfg.field_index);
    assign mag_base  = start_sel ? 64'd0 : magnitude_reg;

    // magnitude * radix + digit, clamped at 2^63
    assign product = cfg.hex_mode ? {mag_base, 4'b0000}
                                  : ({1'b0, mag_base, 3'b000} + {3'b000, mag_base, 1'b0});
    assign sum     = product + {64'd0, digit[3:0]};
    assign acc     = (sum > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : sum[63:0];

    always_comb
    begin
        char_count_next = char_count_reg;
        text_ended_next = text_ended_reg;
        inside_run_next = inside_run_reg;
        runs_seen_next  = runs_seen_reg;
        selected_next   = selected_reg;
        phase_next      = phase_reg;
        negative_next   = negative_reg;
        magnitude_next  = magnitude_reg;
        result.status   = ST_NOT_FOUND;
        result.value    = 64'd0;

        if (step)
        begin
            if (!text_ended_reg)
            begin
                if (text_byte == 8'd0)
                begin
                    text_ended_next = 1'b1;
                end
                else
                begin
                    if (char_count_reg <= LEN_LIMIT)
                    begin
                        char_count_next = char_count_reg + CW'(1);
                    end
                    if (!run_char)
                    begin
                        inside_run_next = 1'b0;
                        selected_next   = 1'b0;
                    end
                    else
                    begin
                        if (!inside_run_reg)
                        begin
                            inside_run_next = 1'b1;
                            if (start_sel)
                            begin
                                selected_next  = 1'b1;
                                phase_next     = PH_SIGN;
                                negative_next  = 1'b0;
                                magnitude_next = 64'd0;
                            end
                            if (runs_seen_reg < RUN_CAP)
                            begin
                                runs_seen_next = runs_seen_reg + 4'd1;
                            end
                        end
                        if (selected_next && phase_next != PH_DONE)
                        begin
                            if (is_digit)
                            begin
                                magnitude_next = acc;
                                phase_next     = PH_DIGITS;
                            end
                            else if (phase_next == PH_SIGN)
                            begin
                                negative_next = 1'b1;
                                phase_next    = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                    end
                end
            end

            if (last_byte)
            begin
                if (char_count_next > LEN_LIMIT)
                begin
                    result.status = ST_TOO_LONG;
                end
                else if (runs_seen_next > cfg.field_index)
                begin
                    result.status = ST_OK;
                    if (negative_next)
                    begin
                        result.value = 64'd0 - magnitude_next;
                    end
                    else
                    begin
                        result.value = magnitude_next[63] ? POS_MAX : magnitude_next;
                    end
                end
                char_count_next = '0;
                text_ended_next = 1'b0;
                inside_run_next = 1'b0;
                runs_seen_next  = 4'd0;
                selected_next   = 1'b0;
                phase_next      = PH_SIGN;
                negative_next   = 1'b0;
                magnitude_next  = 64'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg <= '0;
            text_ended_reg <= 1'b0;
            inside_run_reg <= 1'b0;
            runs_seen_reg  <= 4'd0;
            selected_reg   <= 1'b0;
            phase_reg      <= PH_SIGN;
            negative_reg   <= 1'b0;
            magnitude_reg  <= 64'd0;
        end
        else
        begin
            char_count_reg <= char_count_next;
            text_ended_reg <= text_ended_next;
            inside_run_reg <= inside_run_next;
            runs_seen_reg  <= runs_seen_next;
            selected_reg   <= selected_next;
            phase_reg      <= phase_next;
            negative_reg   <= negative_next;
            magnitude_reg  <= magnitude_next;
        end
    end

endmodule

@@ hdl/numeric_field_extractor.sv @@
// Numeric field extractor.
// Text channel (text_valid/text_ready, text_byte, last_byte): one byte per
// transfer; a zero byte ends the text, last_byte closes it and asks for a result.
// Result channel (result_valid/result_ready, status, value): one transfer per
// text, issued for the byte marked last_byte.
// Registers over APB: field_index at 0x0, hex_mode at 0x4; write them only
// while no text is in progress.
// Scanning: a byte is scanned while it sits in the input register; the result
// register is loaded from the scan of the byte marked last_byte.
// Throughput: one byte per cycle unless a result stall holds the input register,
// set by the accumulate (magnitude times radix plus digit) on the scan state.
// Result stall: bytes keep flowing while a result waits; only a second last
// byte holds in the input register until the pending result is taken.
// Reset clears the scan state, both registers and both channels.
module numeric_field_extractor
    import nfe_pkg::*;
#(
    parameter int MAX_TEXT_LEN = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                text_valid,
    output logic                text_ready,
    input  logic [7:0]          text_byte,
    input  logic                last_byte,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [1:0]          status,
    output logic signed [63:0]  value
);

    cfg_t    cfg;
    result_t scan_result;

    logic       hold_valid_reg;
    logic [7:0] hold_byte_reg;
    logic       hold_last_reg;
    logic       result_valid_reg;
    result_t    result_reg;
    logic       step;

    nfe_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign step = hold_valid_reg && (!hold_last_reg || !result_valid_reg || result_ready);
    assign text_ready = !hold_valid_reg || step;

    nfe_scan #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .text_byte (hold_byte_reg),
        .last_byte (hold_last_reg),
        .result    (scan_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (text_ready)
        begin
            hold_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            hold_byte_reg <= text_byte;
            hold_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (step && hold_last_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && hold_last_reg)
        begin
            result_reg <= scan_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = result_reg.status;
    assign value        = result_reg.value;

endmodule

@@ bench/tb_numeric_field_extractor.sv @@
module tb_numeric_field_extractor;
    import nfe_pkg::*;

    localparam int TEXT_LIMIT   = 256;
    localparam int RANDOM_BYTES = 700;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum logic [1:0]
    {
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } parse_phase_e;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               text_valid;
    logic               text_ready;
    logic [7:0]         text_byte;
    logic               last_byte;
    logic               result_valid;
    logic               result_ready;
    logic [1:0]         status;
    logic signed [63:0] value;

    // scan state mirror
    logic [3:0]   sel_index;
    logic         hex_sel;
    int           n_chars;
    bit           text_done;
    bit           in_run;
    int           run_count;
    bit           sel_open;
    parse_phase_e phase;
    bit           neg;
    logic [63:0]  mag;

    result_t expected_results[$];
    int      errors;
    int      cycles;
    int      random_bytes;
    bit      steady_send;
    int      stall_left;
    int      steady_left;

    numeric_field_extractor #(.MAX_TEXT_LEN(TEXT_LIMIT)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_byte    (text_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .value        (value)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 25);
    endfunction

    function automatic int digit_value(logic [7:0] c, logic hex);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return int'(c) - 48;
        end
        if (hex && c >= 8'h61 && c <= 8'h66)
        begin
            return int'(c) - 87;
        end
        if (hex && c >= 8'h41 && c <= 8'h46)
        begin
            return int'(c) - 55;
        end
        return -1;
    endfunction

    function automatic void clear_scan();
        n_chars   = 0;
        text_done = 0;
        in_run    = 0;
        run_count = 0;
        sel_open  = 0;
        phase     = PH_SIGN;
        neg       = 0;
        mag       = '0;
    endfunction

    function automatic void accumulate_digit(int d);
        logic [63:0] radix;
        radix = hex_sel ? 64'd16 : 64'd10;
        if (mag > (MAG_LIMIT - 64'(d)) / radix)
        begin
            mag = MAG_LIMIT;
        end
        else
        begin
            mag = mag * radix + 64'(d);
        end
    endfunction

    function automatic void scan_char(logic [7:0] c);
        int d;
        bit run_char;
        d = digit_value(c, hex_sel);
        run_char = (d >= 0) || (c == SIGN_CHAR);
        if (n_chars <= TEXT_LIMIT)
        begin
            n_chars++;
        end
        if (!run_char)
        begin
            in_run   = 0;
            sel_open = 0;
            return;
        end
        if (!in_run)
        begin
            in_run = 1;
            if (run_count < int'(RUN_CAP) && run_count == int'(sel_index))
            begin
                sel_open = 1;
                phase    = PH_SIGN;
                neg      = 0;
                mag      = '0;
            end
            if (run_count < int'(RUN_CAP))
            begin
                run_count++;
            end
        end
        if (!sel_open || phase == PH_DONE)
        begin
            return;
        end
        if (d >= 0)
        begin
            accumulate_digit(d);
            phase = PH_DIGITS;
        end
        else if (phase == PH_SIGN)
        begin
            neg   = 1;
            phase = PH_DIGITS;
        end
        else
        begin
            phase = PH_DONE;
        end
    endfunction

    function automatic void predict_transfer(logic [7:0] c, logic l);
        result_t r;
        if (!text_done)
        begin
            if (c == 8'h00)
            begin
                text_done = 1;
            end
            else
            begin
                scan_char(c);
            end
        end
        if (!l)
        begin
            return;
        end
        r.value = '0;
        if (n_chars > TEXT_LIMIT)
        begin
            r.status = ST_TOO_LONG;
        end
        else if (run_count > int'(sel_index))
        begin
            r.status = ST_OK;
            if (neg)
            begin
                r.value = 64'd0 - mag;
            end
            else
            begin
                r.value = (mag >= MAG_LIMIT) ? POS_MAX : mag;
            end
        end
        else
        begin
            r.status = ST_NOT_FOUND;
        end
        expected_results.push_back(r);
        clear_scan();
    endfunction

    function automatic void check_result();
        result_t e;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual status %0d value %0d",
                     $time, status, value);
            errors++;
            return;
        end
        e = expected_results.pop_front();
        if (status !== e.status)
        begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, status);
            errors++;
        end
        if (value !== e.value)
        begin
            $display("%0t: value mismatch: expected %0d, actual %0d",
                     $time, $signed(e.value), value);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_sink
        int r;
        if (rst_n && result_valid && result_ready)
        begin
            check_result();
        end
        if (steady_left > 0)
        begin
            steady_left--;
            result_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                steady_left = $urandom_range(20, 80);
                result_ready <= 1'b1;
            end
            else if (r < 35)
            begin
                stall_left = idle_len() - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(logic [7:0] c, logic l);
        text_valid <= 1'b1;
        text_byte  <= c;
        last_byte  <= l;
        @(posedge clk);
        while (!text_ready)
        begin
            @(posedge clk);
        end
        predict_transfer(c, l);
        random_bytes++;
        if (!steady_send && $urandom_range(0, 99) < 40)
        begin
            text_valid <= 1'b0;
            repeat (idle_len()) @(posedge clk);
        end
    endtask

    task automatic send_text(logic [7:0] txt[$]);
        steady_send = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < txt.size(); i++)
        begin
            send_byte(txt[i], i == txt.size() - 1);
        end
    endtask

    task automatic send_str(string s);
        logic [7:0] q[$];
        for (int i = 0; i < s.len(); i++)
        begin
            q.push_back(s[i]);
        end
        send_text(q);
    endtask

    task automatic wait_idle();
        text_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic sel, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({sel, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic set_config(logic [3:0] idx, logic hex);
        logic [DATA_W-1:0] junk;
        wait_idle();
        junk = $urandom;
        write_reg(REG_FIELD_INDEX, {junk[DATA_W-1:4], idx});
        junk = $urandom;
        write_reg(REG_HEX_MODE, {junk[DATA_W-1:1], hex});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sel_index = idx;
        hex_sel   = hex;
    endtask

    function automatic logic [7:0] rand_digit(logic hex);
        string hex_set;
        string dec_set;
        hex_set = "0123456789abcdefABCDEF";
        dec_set = "0123456789";
        if (hex)
        begin
            return hex_set[$urandom_range(0, 21)];
        end
        return dec_set[$urandom_range(0, 9)];
    endfunction

    function automatic logic [7:0] rand_sep();
        string seps;
        seps = " ,;:=/+xyzgGqQ";
        return seps[$urandom_range(0, seps.len() - 1)];
    endfunction

    function automatic void build_text(ref logic [7:0] txt[$]);
        int kind;
        int len;
        int pos;
        txt.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 85)
        begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    txt.push_back(rand_digit(hex_sel));
                end
                else
                begin
                    txt.push_back(8'($urandom_range(0, 255)));
                end
            end
            return;
        end
        if ($urandom_range(0, 2) == 0)
        begin
            txt.push_back(rand_sep());
        end
        for (int t = $urandom_range(1, 6); t > 0; t--)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                txt.push_back(SIGN_CHAR);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 6);
            for (int i = 0; i < len; i++)
            begin
                txt.push_back(rand_digit(hex_sel));
            end
            for (int i = $urandom_range(1, 2); i > 0; i--)
            begin
                txt.push_back(rand_sep());
            end
        end
        if ($urandom_range(0, 1) == 0)
        begin
            void'(txt.pop_back());
        end
        if (txt.size() == 0)
        begin
            txt.push_back(rand_digit(hex_sel));
        end
        if (kind >= 70)
        begin
            for (int i = $urandom_range(1, 2); i > 0; i--)
            begin
                pos = $urandom_range(0, txt.size() - 1);
                case ($urandom_range(0, 2))
                    0: txt[pos] = 8'h00;
                    1: txt[pos] = SIGN_CHAR;
                    default: txt[pos] = 8'($urandom_range(0, 255));
                endcase
            end
        end
    endfunction

    task automatic test_directed();
        logic [7:0] q[$];
        set_config(4'd0, 1'b0);
        send_str("-7");
        send_str("-");
        send_str("8-3");
        send_str("--5");
        q = {8'h00};
        send_text(q);
        q = {8'hFF};
        send_text(q);
        q = {8'h35, 8'h00, 8'h37};
        send_text(q);
        q = {8'h33, 8'h00};
        send_text(q);
        set_config(4'd1, 1'b0);
        send_str("a12 b-4");
        send_str("9");
        set_config(4'd15, 1'b1);
        send_str("1 2 3");
        set_config(4'd0, 1'b1);
        send_str("Ff");
        send_str("g-A0");
    endtask

    task automatic test_overflow();
        set_config(4'd0, 1'b0);
        send_str("9223372036854775807");
        send_str("9223372036854775808");
        send_str("-9223372036854775808");
        send_str("-99999999999999999999");
        send_str("x123456789012345678901234");
        set_config(4'd0, 1'b1);
        send_str("7fffffffffffffff");
        send_str("-8000000000000000");
        send_str("fffffffffffffffff");
        send_str("-FFFFFFFFFFFFFFFFF");
    endtask

    task automatic test_run_cap();
        string s;
        s = "";
        for (int i = 0; i < 18; i++)
        begin
            s = {s, $sformatf("%0d ", i)};
        end
        set_config(4'd14, 1'b0);
        send_str(s);
        set_config(4'd15, 1'b0);
        send_str(s);
    endtask

    task automatic test_too_long();
        logic [7:0] q[$];
        int sizes[4];
        sizes = '{256, 257, 520, 260};
        set_config(4'd0, 1'b0);
        foreach (sizes[k])
        begin
            q = {8'h34, 8'h32};
            while (q.size() < sizes[k])
            begin
                q.push_back(8'h20);
            end
            if (k == 3)
            begin
                q[10] = 8'h00;
            end
            send_text(q);
        end
    endtask

    task automatic test_random();
        logic [7:0] txt[$];
        int n;
        logic [3:0] idx;
        logic hex;
        random_bytes = 0;
        n = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            case (n)
                0: begin idx = 4'd0;  hex = 1'b0; end
                1: begin idx = 4'd15; hex = 1'b1; end
                2: begin idx = 4'd0;  hex = 1'b1; end
                3: begin idx = 4'd15; hex = 1'b0; end
                default:
                begin
                    idx = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 5))
                                                       : 4'($urandom_range(0, 15));
                    hex = 1'($urandom_range(0, 1));
                end
            endcase
            set_config(idx, hex);
            for (int t = 0; t < 5; t++)
            begin
                build_text(txt);
                send_text(txt);
            end
            n++;
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        text_valid   = 1'b0;
        text_byte    = 8'h00;
        last_byte    = 1'b0;
        result_ready = 1'b0;
        sel_index    = 4'd0;
        hex_sel      = 1'b0;
        clear_scan();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_overflow();
        test_run_cap();
        test_too_long();
        test_random();
        wait_idle();
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/nfe_pkg.sv
hdl/nfe_cfg.sv
hdl/nfe_scan.sv
hdl/numeric_field_extractor.sv
bench/tb_numeric_field_extractor.sv
